### rtl/kdac_pkg.sv
// Shared types, constants and build-time ladder functions for the R-2R DAC level model.
// Used by kdac_sum, kdac_sat and the top level; depends on nothing.

package kdac_pkg;

  // Widths of the fixed fields and of the internal datapath
  localparam int unsigned MAX_DAC_BITS = 16;
  localparam int unsigned CODE_W       = 12;
  localparam int unsigned WEIGHT_W     = 25;  // Q0.24 with room for exactly 1.0
  localparam int unsigned X_W          = 25;  // ladder sum, Q0.24, never above 1.0
  localparam int unsigned DIFF_W       = 31;  // 110*x - 11*x^3, below 110 * 2^24
  localparam int unsigned LEVEL_W      = 17;  // Q0.16 result, 65536 means 1.0
  localparam int unsigned LEAK_W       = 17;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 17'd65536;
  localparam logic [LEAK_W-1:0]  LEAK_UNTERM = 17'd125829;  // 0.0075 in Q0.24
  localparam logic [LEAK_W-1:0]  LEAK_TERM   = 17'd58720;   // 0.0035 in Q0.24

  // Division by 100 as a multiply by ceil(2^38 / 100); exact for inputs below 2^31
  localparam logic [31:0] RECIP_100   = 32'd2748779070;
  localparam int unsigned RECIP_SHIFT = 38;

  // Cubic curve coefficients, scaled by 100
  localparam logic [6:0] SAT_LIN = 7'd110;
  localparam logic [3:0] SAT_CUB = 4'd11;

  // Rounding constant for the Q0.24 to Q0.16 step
  localparam logic [X_W-1:0] ROUND_HALF = 25'd128;

  // Configuration register word indexes
  localparam logic REG_CHIP_MODEL = 1'b0;

  typedef enum logic {
    MODEL_UNTERM = 1'b0,
    MODEL_TERM   = 1'b1
  } chip_model_t;

  typedef logic [MAX_DAC_BITS-1:0][WEIGHT_W-1:0] wtab_t;

  // Ladder sum handed from the summing pipeline to the saturation pipeline
  typedef struct packed {
    logic [X_W-1:0] x;
    logic           sat;
  } sum_t;

  // Truncating unsigned division by shift and subtract, used by the table functions only.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Per-bit ladder weights in Q0.24, evaluated at elaboration only.
  // Resistances are Q24 in resistor units, voltages Q28, every division truncates.
  function automatic wtab_t ladder_weights(input int unsigned n, input logic term);
    longint unsigned r;
    longint unsigned t;
    longint unsigned rn;
    longint unsigned v;
    longint unsigned p;
    longint unsigned total;
    longint unsigned volts [MAX_DAC_BITS];
    logic            closed;
    wtab_t           w;
    r     = 64'd5 << 24;
    t     = (term ? 64'd10 : 64'd11) << 24;
    total = 64'd0;
    w     = '0;
    for (int s = 0; s < MAX_DAC_BITS; s++) begin
      volts[s] = 64'd0;
      if (s < int'(n)) begin
        closed = term;
        rn     = term ? t : 64'd0;
        // Tail below the bit
        for (int b = 0; b < s; b++) begin
          if (!closed) begin
            rn     = r + t;
            closed = 1'b1;
          end else begin
            rn = r + udiv(t * rn, t + rn);
          end
        end
        if (!closed) begin
          rn = t;
          v  = 64'd1 << 28;
        end else begin
          rn = udiv(t * rn, t + rn);
          v  = udiv((64'd1 << 28) * rn, t);
        end
        // Attenuation through the rungs above the bit
        for (int b = s + 1; b < int'(n); b++) begin
          rn = rn + r;
          p  = udiv(t * rn, t + rn);
          v  = udiv(v * p, rn);
          rn = p;
        end
        volts[s] = v;
        total    = total + v;
      end
    end
    for (int s = 0; s < MAX_DAC_BITS; s++) begin
      if (s < int'(n) && total != 64'd0) begin
        w[s] = WEIGHT_W'(udiv(volts[s] << 24, total));
      end
    end
    return w;
  endfunction

  // Contribution of a clear bit: weight times leakage, truncated to Q0.24
  function automatic wtab_t leak_weights(input int unsigned n, input logic term);
    wtab_t           w;
    wtab_t           lw;
    longint unsigned prod;
    longint unsigned leak;
    w    = ladder_weights(n, term);
    lw   = '0;
    leak = term ? 64'(LEAK_TERM) : 64'(LEAK_UNTERM);
    for (int s = 0; s < MAX_DAC_BITS; s++) begin
      prod  = 64'(w[s]) * leak;
      lw[s] = WEIGHT_W'(prod >> 24);
    end
    return lw;
  endfunction

endpackage

### rtl/kdac_sum.sv
// Ladder summing pipeline: per-bit weight selection and a two-stage adder tree.
// Depends on kdac_pkg for the build-time weight tables and the sum_t hand-off type.

module kdac_sum #(
  parameter int unsigned DAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [kdac_pkg::CODE_W-1:0]       code,
  input  logic                              sat,
  input  kdac_pkg::chip_model_t             model,
  output logic                              out_valid,
  output kdac_pkg::sum_t                    out_sum
);

  localparam int unsigned NGRP = (DAC_BITS + 3) / 4;

  localparam kdac_pkg::wtab_t W_UNTERM = kdac_pkg::ladder_weights(DAC_BITS, 1'b0);
  localparam kdac_pkg::wtab_t W_TERM   = kdac_pkg::ladder_weights(DAC_BITS, 1'b1);
  localparam kdac_pkg::wtab_t L_UNTERM = kdac_pkg::leak_weights(DAC_BITS, 1'b0);
  localparam kdac_pkg::wtab_t L_TERM   = kdac_pkg::leak_weights(DAC_BITS, 1'b1);

  logic [kdac_pkg::MAX_DAC_BITS-1:0]                   code_ext;
  logic [DAC_BITS-1:0][kdac_pkg::WEIGHT_W-1:0]         term;
  logic [NGRP-1:0][kdac_pkg::X_W-1:0]                  grp_nxt;
  logic [NGRP-1:0][kdac_pkg::X_W-1:0]                  grp_r;
  logic                                                sat1_r;
  logic                                                v1_r;
  logic                                                v1_nxt;
  logic [kdac_pkg::X_W-1:0]                            x_nxt;
  kdac_pkg::sum_t                                      sum_r;
  logic                                                v2_r;
  logic                                                v2_nxt;
  logic [kdac_pkg::X_W-1:0]                            acc;

  // Ladder bits above the code width read as clear
  assign code_ext = kdac_pkg::MAX_DAC_BITS'(code);

  // Each bit contributes its full weight when set, its leaked weight when clear
  always_comb begin
    for (int i = 0; i < int'(DAC_BITS); i++) begin
      if (model == kdac_pkg::MODEL_TERM) begin
        term[i] = code_ext[i] ? W_TERM[i] : L_TERM[i];
      end else begin
        term[i] = code_ext[i] ? W_UNTERM[i] : L_UNTERM[i];
      end
    end
  end

  // First adder level: groups of four terms
  always_comb begin
    for (int g = 0; g < int'(NGRP); g++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < int'(DAC_BITS)) begin
          acc = acc + term[g * 4 + k];
        end
      end
      grp_nxt[g] = acc;
    end
  end

  // Second adder level: the group sums
  always_comb begin
    x_nxt = '0;
    for (int g = 0; g < int'(NGRP); g++) begin
      x_nxt = x_nxt + grp_r[g];
    end
  end

  assign v1_nxt = en ? in_valid : v1_r;
  assign v2_nxt = en ? v1_r : v2_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  // Payload registers move with the pipeline enable
  always_ff @(posedge clk) begin
    if (en) begin
      grp_r     <= grp_nxt;
      sat1_r    <= sat;
      sum_r.x   <= x_nxt;
      sum_r.sat <= sat1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_sum   = sum_r;

endmodule

### rtl/kdac_sat.sv
// Cubic saturation pipeline: square, cube, scaled difference, divide by one hundred.
// Depends on kdac_pkg for the sum_t type, widths and the reciprocal constant.

module kdac_sat (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  kdac_pkg::sum_t            in_sum,
  output logic                      out_valid,
  output logic [kdac_pkg::X_W-1:0]  out_y
);

  localparam int unsigned XX_W  = 2 * kdac_pkg::X_W;
  localparam int unsigned POS_W = kdac_pkg::X_W + 7;
  localparam int unsigned NEG_W = kdac_pkg::X_W + 4;
  localparam int unsigned QP_W  = kdac_pkg::DIFF_W + 32;

  kdac_pkg::sum_t               s3_r;
  kdac_pkg::sum_t               s4_r;
  kdac_pkg::sum_t               s5_r;
  logic [kdac_pkg::X_W-1:0]     x2_r;
  logic [kdac_pkg::X_W-1:0]     x2_nxt;
  logic [kdac_pkg::X_W-1:0]     x3_r;
  logic [kdac_pkg::X_W-1:0]     x3_nxt;
  logic [kdac_pkg::DIFF_W-1:0]  diff_r;
  logic [kdac_pkg::DIFF_W-1:0]  diff_nxt;
  logic [kdac_pkg::X_W-1:0]     y_r;
  logic [kdac_pkg::X_W-1:0]     y_nxt;
  logic [XX_W-1:0]              sq;
  logic [XX_W-1:0]              cube;
  logic [POS_W-1:0]             pos;
  logic [NEG_W-1:0]             neg;
  logic [QP_W-1:0]              qprod;
  logic [3:0]                   v_r;
  logic [3:0]                   v_nxt;

  // Square and cube, each registered before the next multiply
  always_comb begin
    sq     = XX_W'(in_sum.x) * XX_W'(in_sum.x);
    x2_nxt = kdac_pkg::X_W'(sq >> 24);
    cube   = XX_W'(x2_r) * XX_W'(s3_r.x);
    x3_nxt = kdac_pkg::X_W'(cube >> 24);
  end

  // Scaled curve 110x - 11x^3, floored at zero
  always_comb begin
    pos = POS_W'(kdac_pkg::SAT_LIN) * POS_W'(s4_r.x);
    neg = NEG_W'(kdac_pkg::SAT_CUB) * NEG_W'(x3_r);
    if (POS_W'(neg) > pos) begin
      diff_nxt = '0;
    end else begin
      diff_nxt = kdac_pkg::DIFF_W'(pos - POS_W'(neg));
    end
  end

  // Division by one hundred through the reciprocal, then pick curve or linear sum
  always_comb begin
    qprod = QP_W'(diff_r) * QP_W'(kdac_pkg::RECIP_100);
    if (s5_r.sat) begin
      y_nxt = kdac_pkg::X_W'(qprod >> kdac_pkg::RECIP_SHIFT);
    end else begin
      y_nxt = s5_r.x;
    end
  end

  assign v_nxt = en ? {v_r[2:0], in_valid} : v_r;

  // Valid bits of the four stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      s3_r   <= in_sum;
      x2_r   <= x2_nxt;
      s4_r   <= s3_r;
      x3_r   <= x3_nxt;
      s5_r   <= s4_r;
      diff_r <= diff_nxt;
      y_r    <= y_nxt;
    end
  end

  assign out_valid = v_r[3];
  assign out_y     = y_r;

endmodule

### rtl/kinked_r2r_dac_model.sv
// Top level of the non-ideal R-2R ladder DAC level model.
// Depends on kdac_pkg, kdac_sum and kdac_sat.

// The block takes one request per clock cycle while the output is not held, and returns
// each level after it passes the ladder summing pipeline, the saturation arithmetic
// (square, cube, scaled difference, reciprocal divide) and an output register. The
// whole pipeline advances together, so when the output is held by the downstream side
// every stage holds and in_tready falls in the same cycle. The weight tables of both
// ladder models are built at elaboration for the chosen DAC_BITS; chip_model picks one
// of them and should be written only while no request is in flight.

module kinked_r2r_dac_model #(
  parameter int unsigned DAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [11:0] code
  input  logic [0:0]  in_tuser,    // [0] apply_saturation
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [16:0] level
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  kdac_pkg::chip_model_t              model_r;
  logic                               cfg_wr;
  logic                               en;
  logic                               sum_valid;
  kdac_pkg::sum_t                     sum;
  logic                               sat_valid;
  logic [kdac_pkg::X_W-1:0]           y;
  logic [kdac_pkg::X_W:0]             rounded;
  logic [kdac_pkg::LEVEL_W:0]         lvl_wide;
  logic [kdac_pkg::LEVEL_W-1:0]       level_nxt;
  logic [kdac_pkg::LEVEL_W-1:0]       level_r;
  logic                               out_valid_r;
  logic                               out_valid_nxt;

  // Configuration register; word-aligned decode
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r <= kdac_pkg::MODEL_UNTERM;
    end else if (cfg_wr && cfg_paddr[2] == kdac_pkg::REG_CHIP_MODEL) begin
      model_r <= kdac_pkg::chip_model_t'(cfg_pwdata[0]);
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == kdac_pkg::REG_CHIP_MODEL) ? {31'd0, model_r} : 32'd0;

  // The pipeline moves whenever the output register is empty or being drained
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  kdac_sum #(
    .DAC_BITS (DAC_BITS)
  ) u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .code      (in_tdata[kdac_pkg::CODE_W-1:0]),
    .sat       (in_tuser[0]),
    .model     (model_r),
    .out_valid (sum_valid),
    .out_sum   (sum)
  );

  kdac_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sum_valid),
    .in_sum    (sum),
    .out_valid (sat_valid),
    .out_y     (y)
  );

  // Round Q0.24 to Q0.16 and clip at 1.0
  always_comb begin
    rounded  = (kdac_pkg::X_W + 1)'(y) + (kdac_pkg::X_W + 1)'(kdac_pkg::ROUND_HALF);
    lvl_wide = (kdac_pkg::LEVEL_W + 1)'(rounded >> 8);
    if (lvl_wide > (kdac_pkg::LEVEL_W + 1)'(kdac_pkg::LEVEL_MAX)) begin
      level_nxt = kdac_pkg::LEVEL_MAX;
    end else begin
      level_nxt = kdac_pkg::LEVEL_W'(lvl_wide);
    end
  end

  assign out_valid_nxt = en ? sat_valid : out_valid_r;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level_r <= level_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, level_r};

endmodule

### rtl/kdac_chk.sv
// Port-level checker for the R-2R DAC level model, bound to the top level.
// Depends only on the top level's ports.

module kdac_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // The level never exceeds full scale
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:0] <= 17'd65536 && out_tdata[23:17] == 7'd0)
    else $error("level above full scale");

  // Leakage of clear bits keeps every level above zero
  a_level_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:0] != 17'd0)
    else $error("level of zero from a leaky ladder");

  // Input is taken whenever the output register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

endmodule

bind kinked_r2r_dac_model kdac_chk u_kdac_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
